// ===== src/psd2d_pkg.sv =====
// ----------------------------------------------------------------------------
// psd2d_pkg
// Widths and types shared by the point to segment distance block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package psd2d_pkg;

    // Coordinate fields are 24-bit two's complement.
    localparam int COORD_W = 24;
    // The distance result is 25 bits unsigned.
    localparam int DIST_W = 25;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;

endpackage

// ===== src/psd2d_in_if.sv =====
// ----------------------------------------------------------------------------
// psd2d_in_if
// Query channel: a point and the two end points of a segment per beat.
// ----------------------------------------------------------------------------
interface psd2d_in_if;

    logic                valid;
    logic                ready;
    psd2d_pkg::coord_t   point_x;
    psd2d_pkg::coord_t   point_y;
    psd2d_pkg::coord_t   start_x;
    psd2d_pkg::coord_t   start_y;
    psd2d_pkg::coord_t   end_x;
    psd2d_pkg::coord_t   end_y;

    modport source (output valid, output point_x, output point_y, output start_x,
                    output start_y, output end_x, output end_y, input ready);
    modport sink   (input valid, input point_x, input point_y, input start_x,
                    input start_y, input end_x, input end_y, output ready);

endinterface

// ===== src/psd2d_out_if.sv =====
// ----------------------------------------------------------------------------
// psd2d_out_if
// Result channel: one distance per beat.
// ----------------------------------------------------------------------------
interface psd2d_out_if;

    logic               valid;
    logic               ready;
    psd2d_pkg::dist_t   distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);

endinterface

// ===== src/point_segment_distance_2d.sv =====
// Pipeline: differences, products, sums, divider, offset, error, squares, root, output register.
// Throughput: one query per cycle while the skid register is empty; the divider and root are
// unrolled into one stage per quotient or root bit, so no unit is shared between queries.
// Reset: rst_n clears every valid bit, those of the output and skid registers too, at once;
// data registers are not reset. The block is ready for a query as soon as reset is released.
// ----------------------------------------------------------------------------
// point_segment_distance_2d
// Distance from a point to the nearest point of a line segment, fixed point.
// ----------------------------------------------------------------------------
module point_segment_distance_2d #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    psd2d_in_if.sink      query,
    psd2d_out_if.source   result
);

    // Differences are one bit wider than the coordinates, and products of
    // two differences twice that.
    localparam int CW   = psd2d_pkg::COORD_W;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 1;
    localparam int P    = PARAM_FRAC_BITS;
    localparam int TW   = P + 1;
    localparam int OFFW = DW + TW + 1;
    // Error vector components stay within 27 bits, their squares and sum
    // within 2 * QW bits. The root takes one stage per result bit.
    localparam int QW   = DW + 2;
    localparam int SQW  = 2 * QW;
    localparam int NS   = QW;
    localparam int DSTW = psd2d_pkg::DIST_W;

    // The whole pipeline moves together; it stops only while the output
    // skid register holds a beat.
    logic en;

    // ------------------------------------------------------------------
    // Stage 1: segment direction and point offset from the start.
    // ------------------------------------------------------------------
    logic                 s1_v_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_rx_reg, s1_ry_reg;

    assign query.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= query.valid;
            s1_dx_reg <= DW'(query.end_x) - DW'(query.start_x);
            s1_dy_reg <= DW'(query.end_y) - DW'(query.start_y);
            s1_rx_reg <= DW'(query.point_x) - DW'(query.start_x);
            s1_ry_reg <= DW'(query.point_y) - DW'(query.start_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four products for the squared length and dot product.
    // ------------------------------------------------------------------
    logic                 s2_v_reg;
    logic signed [PW-1:0] s2_dxdx_reg, s2_dydy_reg, s2_rxdx_reg, s2_rydy_reg;
    logic signed [DW-1:0] s2_dx_reg, s2_dy_reg, s2_rx_reg, s2_ry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg    <= s1_v_reg;
            s2_dxdx_reg <= s1_dx_reg * s1_dx_reg;
            s2_dydy_reg <= s1_dy_reg * s1_dy_reg;
            s2_rxdx_reg <= s1_rx_reg * s1_dx_reg;
            s2_rydy_reg <= s1_ry_reg * s1_dy_reg;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_rx_reg   <= s1_rx_reg;
            s2_ry_reg   <= s1_ry_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared length and dot product.
    // ------------------------------------------------------------------
    logic                   s3_v_reg;
    logic [PW-1:0]          s3_len2_reg;
    logic signed [DOTW-1:0] s3_dot_reg;
    logic signed [DW-1:0]   s3_dx_reg, s3_dy_reg, s3_rx_reg, s3_ry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg    <= s2_v_reg;
            s3_len2_reg <= PW'($unsigned(s2_dxdx_reg)) + PW'($unsigned(s2_dydy_reg));
            s3_dot_reg  <= DOTW'(s2_rxdx_reg) + DOTW'(s2_rydy_reg);
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;
            s3_rx_reg   <= s2_rx_reg;
            s3_ry_reg   <= s2_ry_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4 and the divider: entry 0 holds the clamp decision, entry k
    // the partial quotient after k restoring steps. The clamp flags ride
    // along; the quotient is only used when neither is set.
    // ------------------------------------------------------------------
    logic                 dv_v_reg    [0:P];
    logic                 dv_zero_reg [0:P];
    logic                 dv_one_reg  [0:P];
    logic [PW-1:0]        dv_rem_reg  [0:P];
    logic [PW-1:0]        dv_den_reg  [0:P];
    logic [P-1:0]         dv_q_reg    [0:P];
    logic signed [DW-1:0] dv_dx_reg   [0:P];
    logic signed [DW-1:0] dv_dy_reg   [0:P];
    logic signed [DW-1:0] dv_rx_reg   [0:P];
    logic signed [DW-1:0] dv_ry_reg   [0:P];

    logic cls_zero;

    // A zero-length segment or a point behind the start gives t = 0, a
    // point past the end gives t = 1.
    assign cls_zero = (s3_len2_reg == '0) || (s3_dot_reg <= 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0]    <= s3_v_reg;
            dv_zero_reg[0] <= cls_zero;
            dv_one_reg[0]  <= !cls_zero && (s3_dot_reg[PW-1:0] >= s3_len2_reg);
            dv_rem_reg[0]  <= s3_dot_reg[PW-1:0];
            dv_den_reg[0]  <= s3_len2_reg;
            dv_q_reg[0]    <= '0;
            dv_dx_reg[0]   <= s3_dx_reg;
            dv_dy_reg[0]   <= s3_dy_reg;
            dv_rx_reg[0]   <= s3_rx_reg;
            dv_ry_reg[0]   <= s3_ry_reg;
        end
    end

    for (genvar k = 1; k <= P; k++)
    begin : g_div
        logic [PW:0] shifted;
        logic        ge;

        assign shifted = {dv_rem_reg[k-1], 1'b0};
        assign ge      = shifted >= {1'b0, dv_den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k]    <= dv_v_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
                dv_one_reg[k]  <= dv_one_reg[k-1];
                dv_rem_reg[k]  <= ge ? PW'(shifted - {1'b0, dv_den_reg[k-1]})
                                     : PW'(shifted);
                dv_den_reg[k]  <= dv_den_reg[k-1];
                dv_q_reg[k]    <= {dv_q_reg[k-1][P-2:0], ge};
                dv_dx_reg[k]   <= dv_dx_reg[k-1];
                dv_dy_reg[k]   <= dv_dy_reg[k-1];
                dv_rx_reg[k]   <= dv_rx_reg[k-1];
                dv_ry_reg[k]   <= dv_ry_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Offset along the segment: d * t, then the floor shift by P.
    // ------------------------------------------------------------------
    logic [TW-1:0] t_sel;

    always_comb
    begin
        if (dv_zero_reg[P])
            t_sel = '0;
        else if (dv_one_reg[P])
            t_sel = TW'(1) << P;
        else
            t_sel = {1'b0, dv_q_reg[P]};
    end

    logic                   m_v_reg;
    logic signed [OFFW-1:0] m_px_reg, m_py_reg;
    logic signed [DW-1:0]   m_rx_reg, m_ry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg  <= dv_v_reg[P];
            m_px_reg <= OFFW'(dv_dx_reg[P]) * $signed({1'b0, t_sel});
            m_py_reg <= OFFW'(dv_dy_reg[P]) * $signed({1'b0, t_sel});
            m_rx_reg <= dv_rx_reg[P];
            m_ry_reg <= dv_ry_reg[P];
        end
    end

    // ------------------------------------------------------------------
    // Error vector, its squares and their sum.
    // ------------------------------------------------------------------
    logic signed [OFFW-1:0] ox_full, oy_full;

    assign ox_full = m_px_reg >>> P;
    assign oy_full = m_py_reg >>> P;

    logic                 e_v_reg;
    logic signed [QW-1:0] e_qx_reg, e_qy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg  <= m_v_reg;
            e_qx_reg <= QW'(m_rx_reg) - QW'(ox_full);
            e_qy_reg <= QW'(m_ry_reg) - QW'(oy_full);
        end
    end

    logic                  sq_v_reg;
    logic signed [SQW-1:0] sq_x_reg, sq_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg <= e_v_reg;
            sq_x_reg <= e_qx_reg * e_qx_reg;
            sq_y_reg <= e_qy_reg * e_qy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, one result bit per stage. Entry 0 holds the
    // radicand; entry j the remainder and partial root after j steps.
    // ------------------------------------------------------------------
    logic           rt_v_reg   [0:NS];
    logic [SQW-1:0] rt_n_reg   [0:NS];
    logic [SQW-1:0] rt_res_reg [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            rt_v_reg[0]   <= sq_v_reg;
            rt_n_reg[0]   <= $unsigned(sq_x_reg) + $unsigned(sq_y_reg);
            rt_res_reg[0] <= '0;
        end
    end

    for (genvar j = 1; j <= NS; j++)
    begin : g_root
        localparam logic [SQW-1:0] RootBit = SQW'(1) << (2 * (NS - j));
        logic [SQW:0] trial;
        logic         ge;

        assign trial = {1'b0, rt_res_reg[j-1]} + {1'b0, RootBit};
        assign ge    = {1'b0, rt_n_reg[j-1]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                rt_v_reg[j]   <= rt_v_reg[j-1];
                rt_n_reg[j]   <= ge ? SQW'({1'b0, rt_n_reg[j-1]} - trial) : rt_n_reg[j-1];
                rt_res_reg[j] <= ge ? (rt_res_reg[j-1] >> 1) + RootBit
                                    : rt_res_reg[j-1] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register. When the output beat is held up,
    // the beat leaving the pipeline parks in the skid register and the
    // pipeline stops until it drains.
    // ------------------------------------------------------------------
    logic            out_v_reg, skid_v_reg;
    logic [DSTW-1:0] out_d_reg, skid_d_reg;
    logic            out_take;
    logic [DSTW-1:0] tail_d;

    assign en       = !skid_v_reg;
    assign out_take = !out_v_reg || result.ready;
    assign tail_d   = rt_res_reg[NS][DSTW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                out_d_reg  <= skid_d_reg;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= rt_v_reg[NS];
                out_d_reg <= tail_d;
            end
        end
        else if (en && rt_v_reg[NS])
        begin
            skid_v_reg <= 1'b1;
            skid_d_reg <= tail_d;
        end
    end

    assign result.valid    = out_v_reg;
    assign result.distance = out_d_reg;

endmodule

// ===== src/psd2d_checker.sv =====
// ----------------------------------------------------------------------------
// psd2d_checker
// Port-level checks on the point to segment distance block.
// ----------------------------------------------------------------------------
module psd2d_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 q_valid,
    input logic                 q_ready,
    input logic                 r_valid,
    input logic                 r_ready,
    input psd2d_pkg::dist_t     r_distance
);

    // Queries accepted whose results have not yet been delivered.
    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (q_valid && q_ready)
            pend_next = pend_next + 8'd1;
        if (r_valid && r_ready)
            pend_next = pend_next - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // A held result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_distance))
        else $error("result changed while stalled");

    // No result appears without a query behind it.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> pend_reg != 8'd0)
        else $error("result without an outstanding query");

    // The input side only stops while a result is waiting at the output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> q_ready)
        else $error("query channel stalled with no result pending");

endmodule

bind point_segment_distance_2d psd2d_checker u_psd2d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (query.valid),
    .q_ready    (query.ready),
    .r_valid    (result.valid),
    .r_ready    (result.ready),
    .r_distance (result.distance)
);

// ===== dv/psd2d_scoreboard.sv =====
// ----------------------------------------------------------------------------
// psd2d_scoreboard
// Predicts the distance for each accepted query and checks results in order.
// ----------------------------------------------------------------------------
class psd2d_scoreboard;

    localparam int T_FRAC = 16;

    longint unsigned pending_distances[$];
    int              error_count;

    function new();
        error_count = 0;
    endfunction

    // Floor division by 2^T_FRAC, rounding toward minus infinity.
    static function longint floor_param(longint v);
        floor_param = v >>> T_FRAC;
    endfunction

    static function longint unsigned floor_root(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function longint unsigned nearest_distance(psd2d_pkg::coord_t px,
            psd2d_pkg::coord_t py, psd2d_pkg::coord_t sx, psd2d_pkg::coord_t sy,
            psd2d_pkg::coord_t ex, psd2d_pkg::coord_t ey);
        longint dx, dy, rx, ry, dot, t, qx, qy;
        longint unsigned len2, rem, quo;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        rx = longint'(px) - longint'(sx);
        ry = longint'(py) - longint'(sy);
        len2 = longint'(dx * dx) + longint'(dy * dy);
        dot = rx * dx + ry * dy;
        t = 0;
        if (len2 != 0 && dot > 0)
        begin
            if (longint'(dot) >= len2)
                t = longint'(1) << T_FRAC;
            else
            begin
                rem = dot;
                quo = 0;
                for (int i = 0; i < T_FRAC; i++)
                begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= len2)
                    begin
                        rem = rem - len2;
                        quo = quo | 1;
                    end
                end
                t = quo;
            end
        end
        qx = rx - floor_param(dx * t);
        qy = ry - floor_param(dy * t);
        return floor_root(longint'(qx * qx) + longint'(qy * qy)) & 64'h1FF_FFFF;
    endfunction

    function void note_query(psd2d_pkg::coord_t px, psd2d_pkg::coord_t py,
            psd2d_pkg::coord_t sx, psd2d_pkg::coord_t sy,
            psd2d_pkg::coord_t ex, psd2d_pkg::coord_t ey);
        pending_distances.push_back(nearest_distance(px, py, sx, sy, ex, ey));
    endfunction

    function void check_distance(psd2d_pkg::dist_t got);
        longint unsigned want;
        if (pending_distances.size() == 0)
        begin
            $display("%0t: unexpected distance %0d", $time, got);
            error_count++;
            return;
        end
        want = pending_distances.pop_front();
        if (want != got)
        begin
            $display("%0t: distance mismatch expected %0d actual %0d", $time, want, got);
            error_count++;
        end
    endfunction

endclass

// ===== dv/point_segment_distance_2d_tb.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_2d_tb
// Streams directed and random point/segment queries through the block with
// random stalls on both channels and checks every distance against a model.
// ----------------------------------------------------------------------------
module point_segment_distance_2d_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth at the default PARAM_FRAC_BITS; allow a little more when draining.
    localparam int PIPE_DEPTH = 52;
    localparam int RANDOM_QUERIES = 1030;

    logic clk;
    logic rst_n;
    bit   sending_done;

    psd2d_in_if  query();
    psd2d_out_if result();

    psd2d_scoreboard distance_board;

    point_segment_distance_2d dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net: the slowest legal run is well under 1 ms.
    initial
    begin
        #5ms;
        $display("point_segment_distance_2d verification failed");
        $finish;
    end

    function automatic psd2d_pkg::coord_t random_coord();
        // Mostly full range, sometimes small values near the origin, sometimes an extreme.
        case ($urandom_range(0, 5))
            0: return psd2d_pkg::coord_t'($urandom_range(0, 2000))
                      - psd2d_pkg::coord_t'(1000);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return psd2d_pkg::coord_t'($urandom);
        endcase
    endfunction

    // Drives one query beat: idles for a random gap, which may be empty, then holds valid until it is taken.
    // Valid stays high after the beat so that queries can follow back to back;
    // it drops only when the next query draws an idle gap.
    task automatic send_query(psd2d_pkg::coord_t px, psd2d_pkg::coord_t py,
                              psd2d_pkg::coord_t sx, psd2d_pkg::coord_t sy,
                              psd2d_pkg::coord_t ex, psd2d_pkg::coord_t ey);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            query.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        query.valid   <= 1'b1;
        query.point_x <= px;
        query.point_y <= py;
        query.start_x <= sx;
        query.start_y <= sy;
        query.end_x   <= ex;
        query.end_y   <= ey;
        @(posedge clk);
        while (!query.ready) @(posedge clk);
        distance_board.note_query(px, py, sx, sy, ex, ey);
        @(negedge clk);
    endtask

    // Directed queries: extremes, degenerate segments and clamping at both ends.
    task automatic directed_queries();
        psd2d_pkg::coord_t mx, mn;
        mx = 24'sh7FFFFF;
        mn = 24'sh800000;
        send_query(0, 0, 0, 0, 0, 0);
        send_query(256, 256, 0, 0, 0, 0);            // zero-length segment
        send_query(mx, mx, mn, mn, mn, mn);          // zero-length, largest distance
        send_query(mn, mn, mx, mx, mx, mx);
        send_query(mx, mn, mn, mx, mn, mx);
        send_query(-512, 0, 0, 0, 256, 0);           // before the start point
        send_query(1024, 0, 0, 0, 256, 0);           // beyond the end point
        send_query(128, 300, 0, 0, 256, 0);          // projects inside
        send_query(100, 77, 0, 0, 300, 300);         // fractional parameter
        send_query(mx, mx, mn, mn, mx, mx);          // full diagonal
        send_query(mn, mx, mn, mn, mx, mx);
        send_query(mx, mn, mx, mx, mn, mn);
        send_query(0, mx, mn, 0, mx, 0);
        send_query(0, mn, mn, 0, mx, 0);
        send_query(mx, 0, 0, mn, 0, mx);
        send_query(-1, -1, 1, 1, -1, 1);
        send_query(mn, mn, 0, 0, mx, mx);
        send_query(5, 7, 3, -2, 3, 9);               // vertical segment
        send_query(24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 24'shD55555, 24'sh0F0F0F, 24'shF0F0F0);
        send_query(24'shAAAAAA, 24'sh555555, 24'shD55555, 24'sh2AAAAA, 24'shF0F0F0, 24'sh0F0F0F);
    endtask

    task automatic random_queries();
        psd2d_pkg::coord_t sx, sy;
        for (int n = 0; n < RANDOM_QUERIES; n++)
        begin
            sx = random_coord();
            sy = random_coord();
            if ($urandom_range(0, 9) == 0)
                send_query(random_coord(), random_coord(), sx, sy, sx, sy);
            else
                send_query(random_coord(), random_coord(), sx, sy,
                           random_coord(), random_coord());
        end
    endtask

    // Result side: a fresh stall drawn for every beat, sometimes none at all.
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid) @(posedge clk);
            distance_board.check_distance(result.distance);
        end
    end

    initial
    begin
        distance_board = new();
        query.valid   = 1'b0;
        query.point_x = '0;
        query.point_y = '0;
        query.start_x = '0;
        query.start_y = '0;
        query.end_x   = '0;
        query.end_y   = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_queries();
        random_queries();
        query.valid <= 1'b0;

        // Drain: every expected distance must turn up, then let the pipe settle.
        while (distance_board.pending_distances.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        if (distance_board.error_count == 0 &&
            distance_board.pending_distances.size() == 0)
            $display("point_segment_distance_2d verification clean");
        else
            $display("point_segment_distance_2d verification failed");
        $finish;
    end

endmodule
